[hw/rtl/pwau_pkg.sv]
// ----------------------------------------------------------------------------
// pwau_pkg
// Shared types and constants of the soft-PLC word arithmetic unit: opcodes,
// field widths, saturation limits and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pwau_pkg;

  localparam int WORDS_DEF = 1024;
  localparam int OPC_W     = 4;
  localparam int ADDR_W    = 10;
  localparam int WORD_W    = 16;
  localparam int RES_W     = 32;
  localparam int WIDE_W    = 34;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD16   = 4'd0,
    OP_ADDS16  = 4'd1,
    OP_SUB16   = 4'd2,
    OP_SUBS16  = 4'd3,
    OP_MUL16   = 4'd4,
    OP_MULS16  = 4'd5,
    OP_ADD32   = 4'd6,
    OP_ADDS32  = 4'd7,
    OP_ADDS32D = 4'd8,
    OP_SUB32   = 4'd9,
    OP_MUL32   = 4'd10,
    OP_WRITE   = 4'd11,
    OP_READ    = 4'd12
  } op_t;

  localparam logic signed [WIDE_W-1:0] S16_MAX = 34'sd32767;
  localparam logic signed [WIDE_W-1:0] S16_MIN = -34'sd32768;
  localparam logic signed [WIDE_W-1:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN = -34'sd2147483648;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic exec;
    logic fin;
    logic wr_lo;
    logic wr_hi;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pair;
    logic has_write;
    logic out_busy;
  } status_t;

endpackage

[hw/rtl/plc_word_arith_unit_core.sv]
// ----------------------------------------------------------------------------
// plc_word_arith_unit_core
// Soft-PLC arithmetic unit over a register file of signed 16-bit words:
// wrapping and saturating 16-bit add, subtract and multiply, wrapping 32-bit
// add, subtract and multiply, saturating 32-bit add, plus word write and read.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  in       in_valid / in_stall  opcode, addr_a, addr_b, addr_d, write_value
//  out      out_valid/out_stall  result_value, saturated, read_word
//
//  A word is taken while the sequencer is idle and then runs read a, read b,
//  execute, finish, write-back (low word, then high word for 32-bit opcodes)
//  and output load; read and unused codes skip write-back. The memory has a
//  single write port, so the two words of a pair are written one after another.
//  Reset clears the sequencer and output valid only; the register file holds
//  no defined contents until written.
//  A finished word waits in the output register while the next one is taken;
//  its result is loaded only once the previous one has gone.
//
module plc_word_arith_unit_core #(
  parameter int WORDS = pwau_pkg::WORDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pwau_pkg::OPC_W-1:0]           in_opcode,
  input  logic [pwau_pkg::ADDR_W-1:0]          in_addr_a,
  input  logic [pwau_pkg::ADDR_W-1:0]          in_addr_b,
  input  logic [pwau_pkg::ADDR_W-1:0]          in_addr_d,
  input  logic signed [pwau_pkg::WORD_W-1:0]   in_write_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pwau_pkg::RES_W-1:0]    out_result_value,
  output logic                                 out_saturated,
  output logic signed [pwau_pkg::WORD_W-1:0]   out_read_word
);
  import pwau_pkg::*;

  cmd_t    cmd;
  status_t status;

  pwau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pwau_dp #(
    .WORDS (WORDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_opcode        (in_opcode),
    .in_addr_a        (in_addr_a),
    .in_addr_b        (in_addr_b),
    .in_addr_d        (in_addr_d),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .out_read_word    (out_read_word)
  );

endmodule

[hw/rtl/pwau_ctrl.sv]
// ----------------------------------------------------------------------------
// pwau_ctrl
// Sequencer of the word arithmetic unit: steps one word through read,
// execute, finish, write-back and output load.
// ----------------------------------------------------------------------------
module pwau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pwau_pkg::status_t status,
  output pwau_pkg::cmd_t    cmd
);
  import pwau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_FIN,
    S_WLO,
    S_WHI,
    S_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b  = 1'b1;
        cmd.cap_a = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = status.has_write ? S_WLO : S_LOAD;
      end
      S_WLO: begin
        cmd.wr_lo = 1'b1;
        state_nxt = status.is_pair ? S_WHI : S_LOAD;
      end
      S_WHI: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait until the output register is free or being taken
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/pwau_dp.sv]
// ----------------------------------------------------------------------------
// pwau_dp
// Datapath of the word arithmetic unit: register file memory with two read
// ports and one write port, operand registers, shared multiplier, adders,
// saturation and the output register.
// ----------------------------------------------------------------------------
module pwau_dp #(
  parameter int WORDS = pwau_pkg::WORDS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pwau_pkg::cmd_t                         cmd,
  output pwau_pkg::status_t                      status,
  input  logic [pwau_pkg::OPC_W-1:0]             in_opcode,
  input  logic [pwau_pkg::ADDR_W-1:0]            in_addr_a,
  input  logic [pwau_pkg::ADDR_W-1:0]            in_addr_b,
  input  logic [pwau_pkg::ADDR_W-1:0]            in_addr_d,
  input  logic signed [pwau_pkg::WORD_W-1:0]     in_write_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pwau_pkg::RES_W-1:0]      out_result_value,
  output logic                                   out_saturated,
  output logic signed [pwau_pkg::WORD_W-1:0]     out_read_word
);
  import pwau_pkg::*;

  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  // address modulo WORDS by restoring subtraction; correct while the quotient stays below 128
  function automatic logic [AW-1:0] wrap(input logic [ADDR_W:0] v);
    int unsigned t;
    t = {21'd0, v};
    for (int k = 6; k >= 0; k--) begin
      if (t >= (WORDS << k)) begin
        t = t - (WORDS << k);
      end
    end
    return t[AW-1:0];
  endfunction

  logic [WORD_W-1:0] mem_r [WORDS];

  logic [OPC_W-1:0]  op_r;
  logic [AW-1:0]     a0_r, a1_r, b0_r, b1_r, d0_r, d1_r;
  logic [WORD_W-1:0] wv_r;
  logic [WORD_W-1:0] rdata0_r, rdata1_r;
  logic [WORD_W-1:0] a_lo_r, a_hi_r;
  logic signed [WIDE_W-1:0] wide_r, wide_nxt;
  logic [RES_W-1:0]  result_r, result_nxt;
  logic              sat_r, sat_nxt;

  logic              out_valid_r;
  logic [RES_W-1:0]  out_result_r;
  logic              out_sat_r;
  logic [WORD_W-1:0] out_rdw_r;

  logic              is_pair;
  logic              is_read;
  logic [AW-1:0]     raddr0, raddr1;
  logic [WORD_W-1:0] wdata_lo;

  logic [WORD_W-1:0] b_lo, b_hi;
  logic signed [WIDE_W-1:0] xw16, yw16, xw32, yw32;
  logic [RES_W-1:0]  mul_a, mul_b;
  logic [RES_W-1:0]  prod_w;

  // item and address registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= in_opcode;
      wv_r <= in_write_value;
      a0_r <= wrap({1'b0, in_addr_a});
      a1_r <= wrap({1'b0, in_addr_a} + 11'd1);
      b0_r <= wrap({1'b0, in_addr_b});
      b1_r <= wrap({1'b0, in_addr_b} + 11'd1);
      d0_r <= wrap({1'b0, in_addr_d});
      d1_r <= wrap({1'b0, in_addr_d} + 11'd1);
    end
  end

  assign is_pair = (op_r == OP_ADD32) || (op_r == OP_ADDS32) || (op_r == OP_ADDS32D) ||
                   (op_r == OP_SUB32) || (op_r == OP_MUL32);
  assign is_read = (op_r == OP_READ);

  assign status.is_pair   = is_pair;
  assign status.has_write = (op_r <= OP_MUL32) || (op_r == OP_WRITE);
  assign status.out_busy  = out_valid_r && out_stall;

  // register file
  assign raddr0   = cmd.rd_a ? a0_r : b0_r;
  assign raddr1   = cmd.rd_a ? a1_r : b1_r;
  assign wdata_lo = (op_r == OP_WRITE) ? wv_r : result_r[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_a || cmd.rd_b) begin
      rdata0_r <= mem_r[raddr0];
      rdata1_r <= mem_r[raddr1];
    end
    if (cmd.wr_lo) begin
      mem_r[d0_r] <= wdata_lo;
    end else if (cmd.wr_hi) begin
      mem_r[d1_r] <= result_r[RES_W-1:WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_lo_r <= rdata0_r;
      a_hi_r <= rdata1_r;
    end
  end

  // operands: b pair is still on the read registers during execute
  assign b_lo = rdata0_r;
  assign b_hi = rdata1_r;
  assign xw16 = {{(WIDE_W-WORD_W){a_lo_r[WORD_W-1]}}, a_lo_r};
  assign yw16 = {{(WIDE_W-WORD_W){b_lo[WORD_W-1]}}, b_lo};
  assign xw32 = {{(WIDE_W-RES_W){a_hi_r[WORD_W-1]}}, a_hi_r, a_lo_r};
  assign yw32 = {{(WIDE_W-RES_W){b_hi[WORD_W-1]}}, b_hi, b_lo};

  // one multiplier for both widths: the low half of the product is all we keep
  assign mul_a  = is_pair ? {a_hi_r, a_lo_r} : xw16[RES_W-1:0];
  assign mul_b  = is_pair ? {b_hi, b_lo} : yw16[RES_W-1:0];
  assign prod_w = mul_a * mul_b;

  always_comb begin
    case (op_r)
      OP_ADD16, OP_ADDS16: wide_nxt = xw16 + yw16;
      OP_SUB16, OP_SUBS16: wide_nxt = xw16 - yw16;
      OP_MUL16, OP_MULS16: wide_nxt = {{(WIDE_W-RES_W){prod_w[RES_W-1]}}, prod_w[RES_W-1:0]};
      OP_ADD32, OP_ADDS32: wide_nxt = xw32 + yw32;
      OP_ADDS32D:          wide_nxt = xw32 + yw16;
      OP_SUB32:            wide_nxt = xw32 - yw32;
      OP_MUL32:            wide_nxt = {{(WIDE_W-RES_W){1'b0}}, prod_w[RES_W-1:0]};
      default:             wide_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      wide_r <= wide_nxt;
    end
  end

  // wrap or clamp into the destination width
  always_comb begin
    sat_nxt    = 1'b0;
    result_nxt = '0;
    case (op_r)
      OP_ADD16, OP_SUB16, OP_MUL16: begin
        result_nxt = {{(RES_W-WORD_W){wide_r[WORD_W-1]}}, wide_r[WORD_W-1:0]};
      end
      OP_ADDS16, OP_SUBS16, OP_MULS16: begin
        if (wide_r > S16_MAX) begin
          result_nxt = S16_MAX[RES_W-1:0];
          sat_nxt    = 1'b1;
        end else if (wide_r < S16_MIN) begin
          result_nxt = S16_MIN[RES_W-1:0];
          sat_nxt    = 1'b1;
        end else begin
          result_nxt = {{(RES_W-WORD_W){wide_r[WORD_W-1]}}, wide_r[WORD_W-1:0]};
        end
      end
      OP_ADD32, OP_SUB32, OP_MUL32: begin
        result_nxt = wide_r[RES_W-1:0];
      end
      OP_ADDS32, OP_ADDS32D: begin
        if (wide_r > S32_MAX) begin
          result_nxt = S32_MAX[RES_W-1:0];
          sat_nxt    = 1'b1;
        end else if (wide_r < S32_MIN) begin
          result_nxt = S32_MIN[RES_W-1:0];
          sat_nxt    = 1'b1;
        end else begin
          result_nxt = wide_r[RES_W-1:0];
        end
      end
      default: begin
        result_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result_r <= result_nxt;
      sat_r    <= sat_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_result_r <= result_r;
      out_sat_r    <= sat_r;
      out_rdw_r    <= is_read ? a_lo_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_saturated    = out_sat_r;
  assign out_read_word    = out_rdw_r;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks plc_word_arith_unit_core against its own model of the register
// file. The run starts with directed words that fill a few registers with
// extreme values and hit every opcode and saturation edge. Random words
// follow, with random gaps on both channels. Source addresses are drawn only
// from registers that have already been written.
// ----------------------------------------------------------------------------
module testbench;
  import pwau_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 1000;
  localparam int MAX_IDLE     = 12;

  localparam logic [OPC_W-1:0] OP_SPARE_LO = 4'd13;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 4'd15;

  class arith_tracker;
    typedef struct {
      logic [RES_W-1:0]  value;
      logic              sat;
      logic [WORD_W-1:0] word;
    } outcome_t;

    logic [WORD_W-1:0] regs [WORDS_DEF];
    outcome_t          due_q [$];
    int                errors = 0;

    function longint clip(longint v, longint lo, longint hi, inout logic flag);
      if (v > hi) begin
        flag = 1'b1;
        return hi;
      end
      if (v < lo) begin
        flag = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function void apply_word(logic [OPC_W-1:0] op, logic [ADDR_W-1:0] a,
                             logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] d,
                             logic [WORD_W-1:0] wv);
      logic [ADDR_W-1:0] a1, b1, d1;
      logic [RES_W-1:0]  pa, pb;
      longint            x, y, r;
      outcome_t          o;
      a1 = a + 1'b1;
      b1 = b + 1'b1;
      d1 = d + 1'b1;
      o.value = '0;
      o.sat   = 1'b0;
      o.word  = '0;
      case (op)
        OP_ADD16, OP_ADDS16, OP_SUB16, OP_SUBS16, OP_MUL16, OP_MULS16: begin
          x = longint'($signed(regs[a]));
          y = longint'($signed(regs[b]));
          if (op == OP_ADD16 || op == OP_ADDS16) r = x + y;
          else if (op == OP_SUB16 || op == OP_SUBS16) r = x - y;
          else r = x * y;
          if (op == OP_ADDS16 || op == OP_SUBS16 || op == OP_MULS16)
            r = clip(r, S16_MIN, S16_MAX, o.sat);
          regs[d] = r[WORD_W-1:0];
          o.value = {{(RES_W-WORD_W){r[WORD_W-1]}}, r[WORD_W-1:0]};
        end
        OP_ADD32, OP_ADDS32, OP_ADDS32D, OP_SUB32, OP_MUL32: begin
          // low word zero-extended, high word carries the sign
          pa = {regs[a1], regs[a]};
          pb = {regs[b1], regs[b]};
          case (op)
            OP_ADD32: o.value = pa + pb;
            OP_SUB32: o.value = pa - pb;
            OP_MUL32: o.value = pa * pb;
            OP_ADDS32: begin
              r = longint'($signed(pa)) + longint'($signed(pb));
              r = clip(r, S32_MIN, S32_MAX, o.sat);
              o.value = r[RES_W-1:0];
            end
            default: begin
              r = longint'($signed(pa)) + longint'($signed(regs[b]));
              r = clip(r, S32_MIN, S32_MAX, o.sat);
              o.value = r[RES_W-1:0];
            end
          endcase
          regs[d]  = o.value[WORD_W-1:0];
          regs[d1] = o.value[RES_W-1:WORD_W];
        end
        OP_WRITE: regs[d] = wv;
        OP_READ:  o.word = regs[a];
        default:  ;
      endcase
      due_q.push_back(o);
    endfunction

    function void check_word(logic [RES_W-1:0] value, logic sat, logic [WORD_W-1:0] word);
      outcome_t o;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected word: value %h sat %b read %h", $time, value, sat, word);
        errors++;
        return;
      end
      o = due_q.pop_front();
      if (value !== o.value) begin
        $display("%0t: result_value expected %h actual %h", $time, o.value, value);
        errors++;
      end
      if (sat !== o.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, o.sat, sat);
        errors++;
      end
      if (word !== o.word) begin
        $display("%0t: read_word expected %h actual %h", $time, o.word, word);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OPC_W-1:0]         in_opcode = '0;
  logic [ADDR_W-1:0]        in_addr_a = '0;
  logic [ADDR_W-1:0]        in_addr_b = '0;
  logic [ADDR_W-1:0]        in_addr_d = '0;
  logic signed [WORD_W-1:0] in_write_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [RES_W-1:0]  out_result_value;
  logic                     out_saturated;
  logic signed [WORD_W-1:0] out_read_word;

  arith_tracker tracker = new();
  bit           filled [WORDS_DEF];
  int           filled_list [$];
  int           cycles = 0;
  int           out_hold = 0;
  bit           in_rush = 1'b0;
  bit           out_rush = 1'b0;

  plc_word_arith_unit_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_addr_a        (in_addr_a),
    .in_addr_b        (in_addr_b),
    .in_addr_d        (in_addr_d),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_saturated    (out_saturated),
    .out_read_word    (out_read_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check each word taken, then draw a stall for the next one
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      tracker.check_word(out_result_value, out_saturated, out_read_word);
      if ($urandom_range(0, 39) == 0) out_rush = !out_rush;
      out_hold = out_rush ? 0 : $urandom_range(0, MAX_IDLE);
      if (out_hold > 0) out_stall <= 1'b1;
    end else if (out_stall) begin
      out_hold--;
      if (out_hold == 0) out_stall <= 1'b0;
    end
  end

  function automatic void mark_filled(logic [ADDR_W-1:0] w);
    if (!filled[w]) begin
      filled[w] = 1'b1;
      filled_list.push_back(int'(w));
    end
  endfunction

  function automatic logic [ADDR_W-1:0] pick_word();
    int x;
    x = filled_list[$urandom_range(0, filled_list.size() - 1)];
    return x[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] pick_pair();
    int                x;
    logic [ADDR_W-1:0] nx;
    repeat (16) begin
      x  = filled_list[$urandom_range(0, filled_list.size() - 1)];
      nx = ADDR_W'(x + 1);
      if (filled[nx]) return x[ADDR_W-1:0];
    end
    // words 0 and 1 are written by the directed part
    return '0;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_dest();
    if ($urandom_range(0, 1) == 0) return pick_word();
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [WORD_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      4:       return 16'h0000;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [OPC_W-1:0] op, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] d,
                           input logic [WORD_W-1:0] wv);
    int gap;
    if (op == OP_WRITE || op <= OP_MULS16) begin
      mark_filled(d);
    end else if (op <= OP_MUL32) begin
      mark_filled(d);
      mark_filled(d + 1'b1);
    end
    if ($urandom_range(0, 39) == 0) in_rush = !in_rush;
    gap = in_rush ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_addr_a      <= a;
    in_addr_b      <= b;
    in_addr_d      <= d;
    in_write_value <= wv;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.apply_word(op, a, b, d, wv);
  endtask

  initial begin
    logic [OPC_W-1:0]  op;
    logic [ADDR_W-1:0] a, b;
    int                pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes into the low registers and the top one
    send_word(OP_WRITE, '0, '0, 10'd0, 16'h7FFF);
    send_word(OP_WRITE, '0, '0, 10'd1, 16'h8000);
    send_word(OP_WRITE, '0, '0, 10'd2, 16'hFFFF);
    send_word(OP_WRITE, '0, '0, 10'd3, 16'h7FFF);
    send_word(OP_WRITE, '0, '0, 10'd4, 16'h0000);
    send_word(OP_WRITE, '0, '0, 10'd1023, 16'h8000);
    send_word(OP_ADDS16, 10'd0, 10'd0, 10'd10, '0);
    send_word(OP_ADD16, 10'd0, 10'd0, 10'd11, '0);
    send_word(OP_SUBS16, 10'd1, 10'd0, 10'd12, '0);
    send_word(OP_SUB16, 10'd1, 10'd0, 10'd13, '0);
    send_word(OP_MULS16, 10'd1, 10'd1, 10'd14, '0);
    send_word(OP_MUL16, 10'd1, 10'd2, 10'd15, '0);
    // sum lands exactly on the limit, no clamp flag
    send_word(OP_ADDS16, 10'd0, 10'd4, 10'd16, '0);
    send_word(OP_ADDS32, 10'd2, 10'd2, 10'd20, '0);
    send_word(OP_ADDS32, 10'd0, 10'd0, 10'd22, '0);
    send_word(OP_ADDS32D, 10'd2, 10'd0, 10'd24, '0);
    send_word(OP_ADDS32D, 10'd2, 10'd4, 10'd26, '0);
    // pair wraps from the top address round to zero
    send_word(OP_ADD32, 10'd1023, 10'd1, 10'd28, '0);
    send_word(OP_SUB32, 10'd0, 10'd2, 10'd1023, '0);
    send_word(OP_MUL32, 10'd1, 10'd2, 10'd30, '0);
    // destination overlaps both source pairs
    send_word(OP_ADD32, 10'd2, 10'd3, 10'd3, '0);
    send_word(OP_READ, 10'd0, '0, '0, '0);
    send_word(OP_READ, 10'd1023, '0, '0, '0);
    send_word(OP_SPARE_LO, 10'd5, 10'd6, 10'd7, 16'h1234);
    send_word(OP_SPARE_LO + 1'b1, '0, '0, '0, '0);
    send_word(OP_SPARE_HI, '1, '1, '1, '1);

    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.due_q.size() != 0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.due_q.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send_word(OP_WRITE, ADDR_W'($urandom), ADDR_W'($urandom), pick_dest(), rand_value());
      end else if (pick < 30) begin
        send_word(OP_READ, pick_word(), ADDR_W'($urandom), ADDR_W'($urandom),
                  WORD_W'($urandom));
      end else if (pick < 34) begin
        op = OPC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        send_word(op, ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom),
                  WORD_W'($urandom));
      end else begin
        op = OPC_W'($urandom_range(OP_ADD16, OP_MUL32));
        if (op <= OP_MULS16) begin
          a = pick_word();
          b = pick_word();
        end else begin
          a = pick_pair();
          b = (op == OP_ADDS32D) ? pick_word() : pick_pair();
        end
        send_word(op, a, b, pick_dest(), WORD_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pwau_pkg.sv
hw/rtl/pwau_ctrl.sv
hw/rtl/pwau_dp.sv
hw/rtl/plc_word_arith_unit_core.sv
dv/testbench.sv
